@@ design/sosf_pkg.sv @@
// Shared types and constants for the sample offset/scale framer.
// No dependencies; used by every module of the block.
package sosf_pkg;

   // Field widths
   localparam int SAMPLE_W = 10;
   localparam int BYTE_W   = 8;
   localparam int FIELD_W  = 5;
   localparam int TAG_W    = 2;

   // Divider widths: dividend is 2*num + span, divisor is 2*span
   localparam int NUM_W  = 20;
   localparam int REM_W  = 21;
   localparam int DIV_W  = 11;
   localparam int QUOT_W = 10;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'd1023;

   // Frame tags for bits 6:5
   localparam logic [TAG_W-1:0] TAG_LOW  = 2'b01;
   localparam logic [TAG_W-1:0] TAG_HIGH = 2'b10;

   // Register indexes
   localparam logic CSR_OFFSET_MIN_CH0 = 1'b0;
   localparam logic CSR_OFFSET_MIN_CH1 = 1'b1;

   // Payload carried through the divider stages
   typedef struct packed {
      logic              channel;
      logic              zero;
      logic [REM_W-1:0]  rem;
      logic [DIV_W-1:0]  divisor;
      logic [QUOT_W-1:0] quot;
   } div_data_type;

endpackage

@@ design/sosf_prep.sv @@
// Front end: captures a sample with its channel minimum, then forms the
// divider operands. Two register stages. Depends on sosf_pkg.
module sosf_prep (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [sosf_pkg::SAMPLE_W-1:0]       in_raw,
   input  logic                                in_channel,
   input  logic [sosf_pkg::SAMPLE_W-1:0]       in_floor,
   output logic                                out_valid,
   input  logic                                out_ready,
   output sosf_pkg::div_data_type              out_data
);

   logic                              a_valid_ff;
   logic [sosf_pkg::SAMPLE_W-1:0]     a_raw_ff;
   logic [sosf_pkg::SAMPLE_W-1:0]     a_floor_ff;
   logic                              a_channel_ff;
   logic                              a_ready;

   logic                              b_valid_ff;
   sosf_pkg::div_data_type            b_data_ff;
   sosf_pkg::div_data_type            b_data_in;
   logic                              b_ready;

   logic [sosf_pkg::SAMPLE_W-1:0]     clamped;
   logic [sosf_pkg::SAMPLE_W-1:0]     diff;
   logic [sosf_pkg::SAMPLE_W-1:0]     span;
   logic [sosf_pkg::NUM_W-1:0]        num;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Stage A: capture sample and selected minimum
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_raw_ff     <= in_raw;
         a_floor_ff   <= in_floor;
         a_channel_ff <= in_channel;
      end
   end

   // Clamp, offset removal, num = diff * 1023 as a shift and subtract
   always_comb begin
      clamped = (a_raw_ff < a_floor_ff) ? a_floor_ff : a_raw_ff;
      diff    = clamped - a_floor_ff;
      span    = sosf_pkg::FULL_SCALE - a_floor_ff;
      num     = {diff, {sosf_pkg::SAMPLE_W{1'b0}}}
                - {{(sosf_pkg::NUM_W-sosf_pkg::SAMPLE_W){1'b0}}, diff};
      b_data_in.channel = a_channel_ff;
      b_data_in.zero    = (a_floor_ff == sosf_pkg::FULL_SCALE);
      // rounding: (2*num + span) / (2*span)
      b_data_in.rem     = {num, 1'b0}
                          + {{(sosf_pkg::REM_W-sosf_pkg::SAMPLE_W){1'b0}}, span};
      b_data_in.divisor = {span, 1'b0};
      b_data_in.quot    = '0;
   end

   // Stage B: divider operands
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

@@ design/sosf_div_stage.sv @@
// One restoring-division stage: resolves a single quotient bit.
// Depends on sosf_pkg.
module sosf_div_stage #(
   parameter int BIT_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sosf_pkg::div_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sosf_pkg::div_data_type  out_data
);

   logic                           valid_ff;
   sosf_pkg::div_data_type         data_ff;
   sosf_pkg::div_data_type         data_in;
   logic [sosf_pkg::REM_W-1:0]     shifted;
   logic [sosf_pkg::REM_W:0]       trial;

   assign in_ready = !valid_ff || out_ready;

   // Trial subtract of the divisor aligned to this bit
   always_comb begin
      shifted = {{(sosf_pkg::REM_W-sosf_pkg::DIV_W){1'b0}}, in_data.divisor} << BIT_INDEX;
      trial   = {1'b0, in_data.rem} - {1'b0, shifted};
      data_in = in_data;
      if (!trial[sosf_pkg::REM_W]) begin
         data_in.rem             = trial[sosf_pkg::REM_W-1:0];
         data_in.quot[BIT_INDEX] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ design/sosf_frame.sv @@
// Output register: forces the zero case and packs the two framed bytes.
// Depends on sosf_pkg.
module sosf_frame (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  sosf_pkg::div_data_type          in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [sosf_pkg::SAMPLE_W-1:0]   out_scaled,
   output logic [sosf_pkg::BYTE_W-1:0]     out_low,
   output logic [sosf_pkg::BYTE_W-1:0]     out_high
);

   logic                              valid_ff;
   logic [sosf_pkg::SAMPLE_W-1:0]     scaled_ff;
   logic [sosf_pkg::BYTE_W-1:0]       low_ff;
   logic [sosf_pkg::BYTE_W-1:0]       high_ff;
   logic [sosf_pkg::SAMPLE_W-1:0]     scaled_in;

   assign in_ready = !valid_ff || out_ready;

   // Divisor of zero gives zero
   assign scaled_in = in_data.zero ? '0 : in_data.quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         scaled_ff <= scaled_in;
         low_ff    <= {in_data.channel, sosf_pkg::TAG_LOW,
                       scaled_in[sosf_pkg::FIELD_W-1:0]};
         high_ff   <= {in_data.channel, sosf_pkg::TAG_HIGH,
                       scaled_in[sosf_pkg::SAMPLE_W-1:sosf_pkg::FIELD_W]};
      end
   end

   assign out_valid  = valid_ff;
   assign out_scaled = scaled_ff;
   assign out_low    = low_ff;
   assign out_high   = high_ff;

endmodule

@@ design/sample_offset_scale_framer.sv @@
// Sample offset/scale framer top level: config registers, front end,
// divider pipeline and output framing. Depends on sosf_pkg and all sosf_* modules.
//
// Usage: a 10-bit sample and its channel bit arrive on the req_ valid/ready
// channel. The channel's minimum (csr registers 0 and 1) is removed, the
// sample rescaled to 0..1023 with round-half-up, and the result is given on
// the rsp_ channel with two framed bytes (tag 01 low, tag 10 high, bit 7 =
// channel). A minimum of 1023 yields 0.
// Pipeline: 13 register stages (two front-end, ten divider stages of one
// quotient bit each, one output register); the first stage loads on the
// accepting edge.
// Throughput: one transfer per cycle while rsp_ready is held high; the divider is fully pipelined.
// Each stage has its own valid bit and advances when the next one is empty
// or moving, so a stalled receiver fills the pipeline and then drops
// req_ready; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and clears both
// minimum registers to 0. The csr port has registered writes, no read-back,
// and is meant to be used while no transfer is in flight.
module sample_offset_scale_framer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sosf_pkg::SAMPLE_W-1:0]   req_raw_sample,
   input  logic                            req_channel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sosf_pkg::SAMPLE_W-1:0]   rsp_scaled_value,
   output logic [sosf_pkg::BYTE_W-1:0]     rsp_low_byte,
   output logic [sosf_pkg::BYTE_W-1:0]     rsp_high_byte,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [sosf_pkg::SAMPLE_W-1:0]   csr_wdata
);

   logic [sosf_pkg::SAMPLE_W-1:0]  offset_min_ch0_ff;
   logic [sosf_pkg::SAMPLE_W-1:0]  offset_min_ch1_ff;
   logic [sosf_pkg::SAMPLE_W-1:0]  floor_sel;

   logic                           div_valid [0:sosf_pkg::QUOT_W];
   logic                           div_ready [0:sosf_pkg::QUOT_W];
   sosf_pkg::div_data_type         div_data  [0:sosf_pkg::QUOT_W];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_min_ch0_ff <= '0;
         offset_min_ch1_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            sosf_pkg::CSR_OFFSET_MIN_CH0: offset_min_ch0_ff <= csr_wdata;
            sosf_pkg::CSR_OFFSET_MIN_CH1: offset_min_ch1_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign floor_sel = req_channel ? offset_min_ch1_ff : offset_min_ch0_ff;

   // Front end
   sosf_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_raw     (req_raw_sample),
      .in_channel (req_channel),
      .in_floor   (floor_sel),
      .out_valid  (div_valid[0]),
      .out_ready  (div_ready[0]),
      .out_data   (div_data[0])
   );

   // Divider: one quotient bit per stage, MSB first
   for (genvar gi = 0; gi < sosf_pkg::QUOT_W; gi++) begin : g_div
      sosf_div_stage #(
         .BIT_INDEX (sosf_pkg::QUOT_W - 1 - gi)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[gi]),
         .in_ready  (div_ready[gi]),
         .in_data   (div_data[gi]),
         .out_valid (div_valid[gi+1]),
         .out_ready (div_ready[gi+1]),
         .out_data  (div_data[gi+1])
      );
   end

   // Output framing
   sosf_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid[sosf_pkg::QUOT_W]),
      .in_ready   (div_ready[sosf_pkg::QUOT_W]),
      .in_data    (div_data[sosf_pkg::QUOT_W]),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_scaled (rsp_scaled_value),
      .out_low    (rsp_low_byte),
      .out_high   (rsp_high_byte)
   );

endmodule
